// File: rtl/core/robot_mode_panel_controller_assert.svh
// assertion macros for the mode panel controller
// used by rtl/core modules; needs a clock and an active-high reset in scope
`ifndef ROBOT_MODE_PANEL_CONTROLLER_ASSERT_SVH
`define ROBOT_MODE_PANEL_CONTROLLER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RMPC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mode panel check failed");

// next-cycle implication, checked outside reset
`define RMPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mode panel check failed");

`endif

// File: rtl/core/rmpc_pkg.sv
// shared types, codes and helpers for the mode panel controller
// no dependencies
`default_nettype none

package rmpc_pkg;

  // timer and register widths
  localparam int TIMER_WIDTH = 16;
  localparam int CFG_WIDTH   = 16;
  localparam int CMP_WIDTH   = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;
  localparam int CFG_INDEX_WIDTH = 8;

  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;

  // register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DEBOUNCE   = CFG_INDEX_WIDTH'(0);
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SLOW_BLINK = CFG_INDEX_WIDTH'(1);
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FAST_BLINK = CFG_INDEX_WIDTH'(2);

  // register reset values
  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = CFG_WIDTH'(50);
  localparam logic [CFG_WIDTH-1:0] SLOW_BLINK_RESET = CFG_WIDTH'(500);
  localparam logic [CFG_WIDTH-1:0] FAST_BLINK_RESET = CFG_WIDTH'(100);

  // mode codes as seen on the result
  localparam logic [1:0] MODE_CODE_CALIBRATE = 2'd0;
  localparam logic [1:0] MODE_CODE_EXPLORE   = 2'd1;
  localparam logic [1:0] MODE_CODE_WAIT      = 2'd2;
  localparam logic [1:0] MODE_CODE_SPEED_RUN = 2'd3;

  // start codes
  localparam logic [1:0] START_NONE      = 2'd0;
  localparam logic [1:0] START_GYRO_CAL  = 2'd1;
  localparam logic [1:0] START_EXPLORE   = 2'd2;
  localparam logic [1:0] START_SPEED_RUN = 2'd3;

  // internal mode register
  typedef enum logic [3:0] {
    MODE_CALIBRATE = 4'b0001,
    MODE_EXPLORE   = 4'b0010,
    MODE_WAIT      = 4'b0100,
    MODE_SPEED_RUN = 4'b1000
  } mode_t;

  typedef struct packed {
    logic button_one_level;
    logic button_two_level;
    logic routine_done;
  } item_t;

  typedef struct packed {
    logic       led_one;
    logic       led_two;
    logic [1:0] mode;
    logic [1:0] start_routine;
  } result_t;

  // saturating tick counter step
  function automatic logic [TIMER_WIDTH-1:0] sat_inc(input logic [TIMER_WIDTH-1:0] v);
    sat_inc = (v == TIMER_MAX) ? v : v + TIMER_WIDTH'(1);
  endfunction

  // one-hot mode to result code
  function automatic logic [1:0] mode_code(input mode_t m);
    case (m)
      MODE_CALIBRATE: mode_code = MODE_CODE_CALIBRATE;
      MODE_EXPLORE:   mode_code = MODE_CODE_EXPLORE;
      MODE_WAIT:      mode_code = MODE_CODE_WAIT;
      MODE_SPEED_RUN: mode_code = MODE_CODE_SPEED_RUN;
      default:        mode_code = MODE_CODE_CALIBRATE;
    endcase
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/robot_mode_panel_controller.sv
// mode panel controller: one request per tick, one result per request.
// latency: a result is valid the cycle after its request is accepted.
// throughput: one request per cycle; the result register frees itself when
// taken, so a request is stalled only while a result waits under stall.
// reset (rst, synchronous) returns calibrate mode, released buttons, zero
// timers and the default blink and debounce registers.
`default_nettype none
`include "robot_mode_panel_controller_assert.svh"

module robot_mode_panel_controller (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                item_valid,
  output logic                                     item_stall,
  input  wire rmpc_pkg::item_t                     item_data,
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output rmpc_pkg::result_t                        result_data,
  input  wire logic                                cfg_write,
  input  wire logic [rmpc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [rmpc_pkg::CFG_WIDTH-1:0]       cfg_data
);

  logic [rmpc_pkg::CFG_WIDTH-1:0]   debounce_ticks;
  logic [rmpc_pkg::CFG_WIDTH-1:0]   slow_blink_ticks;
  logic [rmpc_pkg::CFG_WIDTH-1:0]   fast_blink_ticks;

  rmpc_pkg::mode_t                  mode;
  rmpc_pkg::mode_t                  mode_next;
  logic                             entered;
  logic                             entered_next;
  logic                             busy;
  logic                             busy_next;
  logic                             confirmed;
  logic                             confirmed_next;
  logic                             blink_phase;
  logic                             blink_phase_next;
  logic [rmpc_pkg::TIMER_WIDTH-1:0] blink_elapsed;
  logic [rmpc_pkg::TIMER_WIDTH-1:0] blink_elapsed_next;

  logic [rmpc_pkg::TIMER_WIDTH-1:0] blink_inc;
  logic                             hit_slow;
  logic                             hit_fast;
  logic                             accept;
  logic                             sample_one;
  logic                             sample_two;
  logic                             press_one;
  logic                             press_two;
  logic                             led_one;
  logic                             led_two;
  logic [1:0]                       start_code;

  // handshake: stall only while a result is held
  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= rmpc_pkg::DEBOUNCE_RESET;
      slow_blink_ticks <= rmpc_pkg::SLOW_BLINK_RESET;
      fast_blink_ticks <= rmpc_pkg::FAST_BLINK_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        rmpc_pkg::CFG_DEBOUNCE:   debounce_ticks   <= cfg_data;
        rmpc_pkg::CFG_SLOW_BLINK: slow_blink_ticks <= cfg_data;
        rmpc_pkg::CFG_FAST_BLINK: fast_blink_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // debouncers for both buttons
  rmpc_debounce u_button_one (
    .clk            (clk),
    .rst            (rst),
    .advance        (accept),
    .sample         (sample_one),
    .raw            (item_data.button_one_level),
    .debounce_ticks (debounce_ticks),
    .press          (press_one)
  );

  rmpc_debounce u_button_two (
    .clk            (clk),
    .rst            (rst),
    .advance        (accept),
    .sample         (sample_two),
    .raw            (item_data.button_two_level),
    .debounce_ticks (debounce_ticks),
    .press          (press_two)
  );

  // blink period compares on the advanced timer
  always_comb begin
    blink_inc = rmpc_pkg::sat_inc(blink_elapsed);
    hit_slow  = rmpc_pkg::CMP_WIDTH'(blink_inc) >= rmpc_pkg::CMP_WIDTH'(slow_blink_ticks);
    hit_fast  = rmpc_pkg::CMP_WIDTH'(blink_inc) >= rmpc_pkg::CMP_WIDTH'(fast_blink_ticks);
  end

  // per-mode tick handling
  always_comb begin
    mode_next          = mode;
    entered_next       = entered;
    busy_next          = busy;
    confirmed_next     = confirmed;
    blink_phase_next   = blink_phase;
    blink_elapsed_next = blink_inc;
    sample_one         = 1'b0;
    sample_two         = 1'b0;
    led_one            = 1'b0;
    led_two            = 1'b0;
    start_code         = rmpc_pkg::START_NONE;
    case (mode)
      rmpc_pkg::MODE_CALIBRATE: begin
        if (!entered) begin
          entered_next = 1'b1;
          busy_next    = 1'b1;
          start_code   = rmpc_pkg::START_GYRO_CAL;
        end else if (!busy || item_data.routine_done) begin
          busy_next = 1'b0;
          if (hit_slow) begin
            blink_elapsed_next = '0;
            blink_phase_next   = !blink_phase;
          end
          led_one    = blink_phase_next;
          led_two    = blink_phase_next;
          sample_one = 1'b1;
          if (press_one) begin
            mode_next    = rmpc_pkg::MODE_EXPLORE;
            entered_next = 1'b0;
          end
        end
      end
      rmpc_pkg::MODE_EXPLORE: begin
        led_one = 1'b1;
        if (!entered) begin
          entered_next = 1'b1;
          busy_next    = 1'b1;
          start_code   = rmpc_pkg::START_EXPLORE;
        end else if (busy && item_data.routine_done) begin
          busy_next      = 1'b0;
          confirmed_next = 1'b0;
          mode_next      = rmpc_pkg::MODE_WAIT;
          entered_next   = 1'b0;
        end
      end
      rmpc_pkg::MODE_WAIT: begin
        entered_next = 1'b1;
        if (!confirmed) begin
          if (hit_fast) begin
            blink_elapsed_next = '0;
            blink_phase_next   = !blink_phase;
          end
          led_one    = blink_phase_next;
          sample_one = 1'b1;
          // confirm press restarts the blink timer, phase is kept
          if (press_one) begin
            confirmed_next     = 1'b1;
            led_one            = 1'b0;
            blink_elapsed_next = '0;
          end
        end else begin
          if (hit_slow) begin
            blink_elapsed_next = '0;
            blink_phase_next   = !blink_phase;
          end
          led_two    = blink_phase_next;
          sample_two = 1'b1;
          if (press_two) begin
            mode_next    = rmpc_pkg::MODE_SPEED_RUN;
            entered_next = 1'b0;
          end
        end
      end
      rmpc_pkg::MODE_SPEED_RUN: begin
        led_two = 1'b1;
        if (!entered) begin
          entered_next = 1'b1;
          busy_next    = 1'b1;
          start_code   = rmpc_pkg::START_SPEED_RUN;
        end else if (busy && item_data.routine_done) begin
          busy_next      = 1'b0;
          confirmed_next = 1'b1;
          mode_next      = rmpc_pkg::MODE_WAIT;
          entered_next   = 1'b0;
        end
      end
      default: begin
        mode_next = rmpc_pkg::MODE_CALIBRATE;
      end
    endcase
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= rmpc_pkg::MODE_CALIBRATE;
      entered       <= 1'b0;
      busy          <= 1'b0;
      confirmed     <= 1'b0;
      blink_phase   <= 1'b0;
      blink_elapsed <= '0;
    end else if (accept) begin
      mode          <= mode_next;
      entered       <= entered_next;
      busy          <= busy_next;
      confirmed     <= confirmed_next;
      blink_phase   <= blink_phase_next;
      blink_elapsed <= blink_elapsed_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_data.led_one       <= led_one;
      result_data.led_two       <= led_two;
      result_data.mode          <= rmpc_pkg::mode_code(mode_next);
      result_data.start_routine <= start_code;
    end
  end

  // checks
  `RMPC_ASSERT_NOW(a_no_stall_when_empty, clk, rst, !result_valid, !item_stall)
  `RMPC_ASSERT_NOW(a_busy_only_after_entry, clk, rst, busy, entered)
  `RMPC_ASSERT_NEXT(a_start_sets_busy, clk, rst,
    accept && (start_code != rmpc_pkg::START_NONE), busy && entered)

endmodule

`default_nettype wire

// File: rtl/core/rmpc_debounce.sv
// button debouncer: raw level tracking, saturating hold counter, press detect
// depends on rmpc_pkg
`default_nettype none

module rmpc_debounce (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          advance,
  input  wire logic                          sample,
  input  wire logic                          raw,
  input  wire logic [rmpc_pkg::CFG_WIDTH-1:0] debounce_ticks,
  output logic                               press
);

  logic                               last_raw;
  logic                               stable;
  logic [rmpc_pkg::TIMER_WIDTH-1:0]   elapsed;
  logic [rmpc_pkg::TIMER_WIDTH-1:0]   elapsed_inc;
  logic                               changed;
  logic                               accept_level;

  // what sampling on this tick would do
  always_comb begin
    elapsed_inc  = rmpc_pkg::sat_inc(elapsed);
    changed      = (raw != last_raw);
    accept_level = !changed
                   && (rmpc_pkg::CMP_WIDTH'(elapsed_inc)
                       > rmpc_pkg::CMP_WIDTH'(debounce_ticks))
                   && (raw != stable);
    press        = accept_level && !raw;
  end

  // counter runs every tick, level state only moves when sampled
  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw <= 1'b1;
      stable   <= 1'b1;
      elapsed  <= '0;
    end else if (advance) begin
      if (sample && changed) begin
        elapsed  <= '0;
        last_raw <= raw;
      end else begin
        elapsed <= elapsed_inc;
      end
      if (sample && accept_level) begin
        stable <= raw;
      end
    end
  end

endmodule

`default_nettype wire
